/* rtl/mpd_pkg.sv */
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared types and constants of the multichannel presence debouncer.
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned NUM_CHANNELS = 8;

  localparam int unsigned READ_W  = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 32;

  localparam logic [COUNT_W-1:0] MISS_MAX = 8'hff;

  localparam logic [READ_W-1:0]  PROX_THR_RST = 16'h0300;
  localparam logic [COUNT_W-1:0] ON_DEB_RST   = 8'd1;
  localparam logic [COUNT_W-1:0] OFF_DEB_RST  = 8'd20;
  localparam logic [COUNT_W-1:0] ERR_THR_RST  = 8'd0;

  typedef enum logic [1:0] {
    REG_PROX_THR = 2'd0,
    REG_ON_DEB   = 2'd1,
    REG_OFF_DEB  = 2'd2,
    REG_ERR_THR  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [READ_W-1:0]  prox_thr;
    logic [COUNT_W-1:0] on_deb;
    logic [COUNT_W-1:0] off_deb;
    logic [COUNT_W-1:0] err_thr;
  } cfg_t;

  // what the lanes found for one round, with its flash phase
  typedef struct packed {
    logic [MAX_CHANNELS-1:0] detect_mask;
    logic [MAX_CHANNELS-1:0] fail_mask;
    logic [MAX_CHANNELS-1:0] miss_mask;
    logic                    flash_on;
  } round_t;

  typedef struct packed {
    logic [MAX_CHANNELS-1:0] detect_mask;
    logic [MAX_CHANNELS-1:0] fail_mask;
    logic [MAX_CHANNELS-1:0] drive_mask;
    logic                    reinit_request;
  } result_t;

endpackage

/* rtl/mpd_if.sv */
// ----------------------------------------------------------------------------
// mpd_in_if / mpd_out_if
// Valid/ready channels carrying a polling round and its result word.
// ----------------------------------------------------------------------------
interface mpd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  ack_mask;
  logic [15:0] reading_0;
  logic [15:0] reading_1;
  logic [15:0] reading_2;
  logic [15:0] reading_3;
  logic [15:0] reading_4;
  logic [15:0] reading_5;
  logic [15:0] reading_6;
  logic [15:0] reading_7;
  logic        flash_on;

  modport source (
    output valid, ack_mask, reading_0, reading_1, reading_2, reading_3,
           reading_4, reading_5, reading_6, reading_7, flash_on,
    input  ready
  );
  modport sink (
    input  valid, ack_mask, reading_0, reading_1, reading_2, reading_3,
           reading_4, reading_5, reading_6, reading_7, flash_on,
    output ready
  );
endinterface

interface mpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] detect_mask;
  logic [7:0] fail_mask;
  logic [7:0] drive_mask;
  logic       reinit_request;

  modport source (
    output valid, detect_mask, fail_mask, drive_mask, reinit_request,
    input  ready
  );
  modport sink (
    input  valid, detect_mask, fail_mask, drive_mask, reinit_request,
    output ready
  );
endinterface

/* rtl/mpd_lane.sv */
// ----------------------------------------------------------------------------
// mpd_lane
// One sensor channel: miss counting, failure marking and on/off debounce.
// ----------------------------------------------------------------------------
module mpd_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        ack_i,
  input  logic [mpd_pkg::READ_W-1:0]  reading_i,
  input  mpd_pkg::cfg_t               cfg_i,
  output logic                        detect_o,
  output logic                        fail_o,
  output logic                        miss_nz_o
);
  import mpd_pkg::*;

  logic [COUNT_W-1:0] miss_q, miss_d;
  logic [COUNT_W-1:0] streak_q, streak_d;
  logic               flag_q, flag_d;
  logic [COUNT_W-1:0] miss_inc;
  logic [COUNT_W-1:0] streak_inc;
  logic               present;

  assign miss_inc   = (miss_q == MISS_MAX) ? miss_q : miss_q + COUNT_W'(1);
  assign streak_inc = streak_q + COUNT_W'(1);
  assign present    = (reading_i >= cfg_i.prox_thr);

  always_comb begin
    miss_d   = miss_q;
    streak_d = streak_q;
    flag_d   = flag_q;
    fail_o   = 1'b0;
    if (!ack_i) begin
      miss_d = miss_inc;
      if (miss_inc > cfg_i.err_thr) begin
        fail_o   = 1'b1;
        flag_d   = 1'b0;
        streak_d = '0;
      end
    end else begin
      miss_d = '0;
      if (!flag_q && present) begin
        if (streak_inc > cfg_i.on_deb) begin
          flag_d   = 1'b1;
          streak_d = '0;
        end else begin
          streak_d = streak_inc;
        end
      end else if (flag_q && !present) begin
        if (streak_inc > cfg_i.off_deb) begin
          flag_d   = 1'b0;
          streak_d = '0;
        end else begin
          streak_d = streak_inc;
        end
      end else begin
        streak_d = '0;
      end
    end
  end

  // a silent channel never reports a detection
  assign detect_o  = ack_i & flag_d;
  assign miss_nz_o = |miss_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q   <= '0;
      streak_q <= '0;
      flag_q   <= 1'b0;
    end else if (accept_i) begin
      miss_q   <= miss_d;
      streak_q <= streak_d;
      flag_q   <= flag_d;
    end
  end

  a_ack_clears_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && ack_i |=> miss_q == '0)
    else $error("miss count not cleared after acknowledge");

  a_fail_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && fail_o |=> !flag_q && streak_q == '0)
    else $error("failed channel kept debounce state");

endmodule

/* rtl/mpd_merge.sv */
// ----------------------------------------------------------------------------
// mpd_merge
// Combines the lane masks into a result word and holds it in a two-entry
// output buffer.
// ----------------------------------------------------------------------------
module mpd_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mpd_pkg::round_t   round_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mpd_pkg::result_t  result_o
);
  import mpd_pkg::*;

  result_t res_w;
  result_t head_q, head_d;
  result_t skid_q, skid_d;
  logic    head_vld_q, head_vld_d;
  logic    skid_vld_q, skid_vld_d;
  logic    push, pop;

  always_comb begin
    res_w.detect_mask    = round_i.detect_mask;
    res_w.fail_mask      = round_i.fail_mask;
    res_w.drive_mask     = (round_i.detect_mask & ~round_i.fail_mask) |
                           (round_i.fail_mask & {MAX_CHANNELS{round_i.flash_on}});
    res_w.reinit_request = |round_i.miss_mask;
  end

  assign in_ready_o  = !skid_vld_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = head_vld_q && out_ready_i;
  assign out_valid_o = head_vld_q;
  assign result_o    = head_q;

  always_comb begin
    head_d     = head_q;
    skid_d     = skid_q;
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    if (pop) begin
      if (skid_vld_q) begin
        head_d     = skid_q;
        skid_d     = res_w;
        skid_vld_d = push;
      end else begin
        head_d     = res_w;
        head_vld_d = push;
      end
    end else if (push) begin
      if (!head_vld_q) begin
        head_d     = res_w;
        head_vld_d = 1'b1;
      end else begin
        skid_d     = res_w;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> head_vld_q)
    else $error("skid entry valid while head empty");

  a_fail_no_detect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_vld_q |-> (head_q.fail_mask & head_q.detect_mask) == '0)
    else $error("failed channel reports detection");

  a_stalled_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_vld_q && !out_ready_i |=> head_vld_q && $stable(head_q))
    else $error("pending word changed under stall");

endmodule

/* rtl/multichannel_presence_debouncer.sv */
// ----------------------------------------------------------------------------
// multichannel_presence_debouncer
// Eight-channel proximity presence debouncer with per-channel failure marking.
// ----------------------------------------------------------------------------
// in_i carries one polling round per word: acknowledge mask, eight readings
// and the flash phase. out_o returns one word per round: detect, fail and
// drive masks plus the re-initialize request.
// Each channel has its own lane that updates its miss count, flag and streak
// in the cycle the round is accepted; the merge stage registers the result
// in its output buffer. One round per cycle is accepted while the buffer has
// room; the lane update itself is combinational.
// A two-entry output buffer lets a new round enter while a finished word is
// still waiting; in_i.ready drops only when both entries are full, so a
// stalled receiver holds back the sender after two rounds.
// Reset clears all channel state and loads the register defaults
// (threshold 768, on debounce 1, off debounce 20, error threshold 0).
// Registers sit on the APB port at byte addresses 0, 4, 8 and 12; write them
// only while no round is in flight. pready is tied high.
// ----------------------------------------------------------------------------
module multichannel_presence_debouncer #(
  parameter int unsigned CHANNELS = mpd_pkg::NUM_CHANNELS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mpd_in_if.sink                      in_i,
  mpd_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mpd_pkg::APB_AW-1:0]  paddr,
  input  logic [mpd_pkg::APB_DW-1:0]  pwdata,
  output logic [mpd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import mpd_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  logic [READ_W-1:0]       reading_w [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] detect_w, fail_w, miss_w;
  logic                    in_ready;
  logic                    accept;
  round_t                  round_w;
  result_t                 result_w;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prox_thr <= PROX_THR_RST;
      cfg_q.on_deb   <= ON_DEB_RST;
      cfg_q.off_deb  <= OFF_DEB_RST;
      cfg_q.err_thr  <= ERR_THR_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PROX_THR: cfg_q.prox_thr <= pwdata[READ_W-1:0];
        REG_ON_DEB:   cfg_q.on_deb   <= pwdata[COUNT_W-1:0];
        REG_OFF_DEB:  cfg_q.off_deb  <= pwdata[COUNT_W-1:0];
        REG_ERR_THR:  cfg_q.err_thr  <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PROX_THR: prdata = APB_DW'(cfg_q.prox_thr);
      REG_ON_DEB:   prdata = APB_DW'(cfg_q.on_deb);
      REG_OFF_DEB:  prdata = APB_DW'(cfg_q.off_deb);
      REG_ERR_THR:  prdata = APB_DW'(cfg_q.err_thr);
      default:      prdata = '0;
    endcase
  end

  // lanes
  assign reading_w[0] = in_i.reading_0;
  assign reading_w[1] = in_i.reading_1;
  assign reading_w[2] = in_i.reading_2;
  assign reading_w[3] = in_i.reading_3;
  assign reading_w[4] = in_i.reading_4;
  assign reading_w[5] = in_i.reading_5;
  assign reading_w[6] = in_i.reading_6;
  assign reading_w[7] = in_i.reading_7;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    if (g < CHANNELS) begin : g_on
      mpd_lane u_lane (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .accept_i  (accept),
        .ack_i     (in_i.ack_mask[g]),
        .reading_i (reading_w[g]),
        .cfg_i     (cfg_q),
        .detect_o  (detect_w[g]),
        .fail_o    (fail_w[g]),
        .miss_nz_o (miss_w[g])
      );
    end else begin : g_off
      assign detect_w[g] = 1'b0;
      assign fail_w[g]   = 1'b0;
      assign miss_w[g]   = 1'b0;
    end
  end

  assign round_w.detect_mask = detect_w;
  assign round_w.fail_mask   = fail_w;
  assign round_w.miss_mask   = miss_w;
  assign round_w.flash_on    = in_i.flash_on;

  mpd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .round_i     (round_w),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (result_w)
  );

  assign out_o.detect_mask    = result_w.detect_mask;
  assign out_o.fail_mask      = result_w.fail_mask;
  assign out_o.drive_mask     = result_w.drive_mask;
  assign out_o.reinit_request = result_w.reinit_request;

endmodule
